/* hw/rtl/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, control codes and defaults of the text console char engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

   // screen geometry defaults
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // fixed field widths
   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 11;

   // transaction modes
   localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // control codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h10;
   localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h11;
   localparam logic [CHAR_W-1:0] CH_UP    = 8'h1E;
   localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h1F;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [CHAR_W-1:0] BLANK_COLOR = 8'h0F;

   // operations of the shared adder
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAR_W-1:0] char_code;
      logic [CHAR_W-1:0] color;
      logic [IDX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  cursor_index;
      logic [CHAR_W-1:0] cell_char;
      logic [CHAR_W-1:0] cell_color;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_W-1:0] chr;
      logic [CHAR_W-1:0] color;
   } cell_type;

   localparam cell_type BLANK_CELL = '{chr: CH_NUL, color: BLANK_COLOR};

endpackage

`default_nettype wire

/* hw/rtl/text_console_char_engine.sv */
// ----------------------------------------------------------------------------
// text_console_char_engine
// Character engine for a COLUMNS x ROWS text screen of (char, colour) cells.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one transaction carries mode, char_code, color, cell_index.
//   rsp channel: exactly one transaction per request, with the cursor after
//   the request and, in read mode, the cell that was read.
//   The block takes one request at a time: req_stall is low only while the
//   sequencer is idle. A finished response sits in the output register, so
//   the next request is taken while rsp is stalled; that request then waits
//   to complete until the output register has been emptied.
// Scroll
//   A scroll copies each cell of the lower rows one row up through the
//   single RAM port pair, one read then one write, then blanks the last row.
// Reset
//   After reset the screen RAM is swept to blank, one cell a cycle; no
//   request is taken until it finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_engine #(
   parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire tcce_pkg::req_type req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output tcce_pkg::rsp_type rsp_data
);

   import tcce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int AW    = $clog2(CELLS);
   localparam int COLW  = $clog2(COLUMNS);
   localparam int CELLW = $bits(cell_type);

   localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
   localparam logic [CW-1:0]   COLS_C     = CW'(COLUMNS);
   localparam logic [CW-1:0]   LAST_ROW_C = CW'(CELLS - COLUMNS);
   localparam logic [CW-1:0]   ONE_C      = CW'(1);
   localparam logic [COLW-1:0] COL_LAST   = COLW'(COLUMNS - 1);

   // sequencer states
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CLR     = 5'd1;
   localparam logic [4:0] S_SCR_RD  = 5'd2;
   localparam logic [4:0] S_SCR_WR  = 5'd3;
   localparam logic [4:0] S_SCR_CUR = 5'd4;
   localparam logic [4:0] S_CHAR    = 5'd5;
   localparam logic [4:0] S_PUT     = 5'd6;
   localparam logic [4:0] S_NL1     = 5'd7;
   localparam logic [4:0] S_NL2     = 5'd8;
   localparam logic [4:0] S_BS1     = 5'd9;
   localparam logic [4:0] S_BS2     = 5'd10;
   localparam logic [4:0] S_BS3     = 5'd11;
   localparam logic [4:0] S_LF1     = 5'd12;
   localparam logic [4:0] S_LF2     = 5'd13;
   localparam logic [4:0] S_RT1     = 5'd14;
   localparam logic [4:0] S_RT2     = 5'd15;
   localparam logic [4:0] S_UP1     = 5'd16;
   localparam logic [4:0] S_UP2     = 5'd17;
   localparam logic [4:0] S_RD      = 5'd18;
   localparam logic [4:0] S_RDW     = 5'd19;
   localparam logic [4:0] S_DONE    = 5'd20;

   // what a finished sweep returns to
   localparam logic [1:0] K_INIT = 2'd0;
   localparam logic [1:0] K_WIPE = 2'd1;
   localparam logic [1:0] K_PRE  = 2'd2;
   localparam logic [1:0] K_POST = 2'd3;

   logic [4:0]      state_ff, state_in;
   logic [1:0]      kind_ff, kind_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [CW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   tmp_ff, tmp_in;
   logic [1:0]      rep_ff, rep_in;
   req_type         req_ff, req_in;
   cell_type        cell_ff, cell_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   alu_op_type      alu_op;
   logic [CW-1:0]   alu_a, alu_b;
   logic [CW:0]     alu_res;
   logic [CW-1:0]   alu_sum;
   logic            alu_borrow;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   cell_type        ram_wdata;
   logic [CELLW-1:0] ram_rdata;
   cell_type        rd_cell;

   logic [COLW-1:0] col_inc, col_dec;
   logic            at_end, at_home, out_free;
   logic [CHAR_W-1:0] put_char;

   tcce_alu #(
      .WIDTH (CW)
   ) u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_res)
   );

   tcce_ram #(
      .WIDTH (CELLW),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign alu_sum    = alu_res[CW-1:0];
   assign alu_borrow = alu_res[CW];
   assign rd_cell    = cell_type'(ram_rdata);

   assign col_inc  = (col_ff == COL_LAST) ? '0 : col_ff + COLW'(1);
   assign col_dec  = (col_ff == '0) ? COL_LAST : col_ff - COLW'(1);
   assign at_end   = (cursor_ff == CELLS_C);
   assign at_home  = (cursor_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign put_char = (req_ff.char_code == CH_TAB) ? CH_SPACE : req_ff.char_code;

   // the edit lock can only move down from cell 0 and floors there, so it
   // stays at cell 0 for good and the lock checks reduce to cursor checks
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      ptr_in       = ptr_ff;
      tmp_in       = tmp_ff;
      rep_in       = rep_ff;
      req_in       = req_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      alu_op    = ALU_ADD;
      alu_a     = cursor_ff;
      alu_b     = ONE_C;
      ram_we    = 1'b0;
      ram_waddr = AW'(ptr_ff);
      ram_wdata = BLANK_CELL;
      ram_re    = 1'b0;
      ram_raddr = AW'(alu_sum);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               cell_in = '0;
               unique case (req_data.mode)
                  MODE_CHAR: begin
                     if (req_data.char_code == CH_NUL) begin
                        state_in = S_DONE;
                     end else if (at_end) begin
                        ptr_in   = '0;
                        kind_in  = K_PRE;
                        state_in = S_SCR_RD;
                     end else begin
                        state_in = S_CHAR;
                     end
                  end
                  MODE_READ: begin
                     if (32'(req_data.cell_index) < 32'(CELLS)) begin
                        state_in = S_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  MODE_CLEAR: begin
                     ptr_in   = '0;
                     kind_in  = K_WIPE;
                     state_in = S_CLR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(req_ff.cell_index);
            state_in  = S_RDW;
         end
         S_RDW: begin
            cell_in  = rd_cell;
            state_in = S_DONE;
         end
         S_CLR: begin
            ram_we = 1'b1;
            alu_a  = ptr_ff;
            ptr_in = alu_sum;
            if (alu_sum == CELLS_C) begin
               unique case (kind_ff)
                  K_INIT: begin
                     cursor_in = '0;
                     col_in    = '0;
                     state_in  = S_IDLE;
                  end
                  K_WIPE: begin
                     cursor_in = '0;
                     col_in    = '0;
                     state_in  = S_DONE;
                  end
                  default: state_in = S_SCR_CUR;
               endcase
            end
         end
         S_SCR_RD: begin
            // source cell is one row below the destination pointer
            alu_a    = ptr_ff;
            alu_b    = COLS_C;
            ram_re   = 1'b1;
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            ram_we    = 1'b1;
            ram_wdata = rd_cell;
            alu_a     = ptr_ff;
            ptr_in    = alu_sum;
            // the pointer runs on into the last row, which gets blanked
            state_in  = (alu_sum == LAST_ROW_C) ? S_CLR : S_SCR_RD;
         end
         S_SCR_CUR: begin
            alu_op = ALU_SUB;
            alu_b  = COLS_C;
            if (alu_borrow) begin
               cursor_in = '0;
               col_in    = '0;
            end else begin
               cursor_in = alu_sum;
            end
            state_in = (kind_ff == K_PRE) ? S_CHAR : S_DONE;
         end
         S_CHAR: begin
            unique case (req_ff.char_code) inside
               CH_TAB: begin
                  rep_in   = 2'd3;
                  state_in = S_PUT;
               end
               CH_LF:            state_in = S_NL1;
               CH_CR, CH_DOWN:   state_in = S_DONE;
               CH_BS:            state_in = at_home ? S_DONE : S_BS1;
               CH_LEFT:          state_in = S_LF1;
               CH_RIGHT:         state_in = S_RT1;
               CH_UP:            state_in = S_UP1;
               default: begin
                  rep_in   = 2'd0;
                  state_in = S_PUT;
               end
            endcase
         end
         S_PUT: begin
            if (at_end) begin
               // tab spaces past the end are dropped
               state_in = S_DONE;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = AW'(cursor_ff);
               ram_wdata = '{chr: put_char, color: req_ff.color};
               cursor_in = alu_sum;
               col_in    = col_inc;
               if (rep_ff == 2'd0) begin
                  state_in = S_DONE;
               end else begin
                  rep_in = rep_ff - 2'd1;
               end
            end
         end
         S_NL1: begin
            alu_b    = COLS_C;
            tmp_in   = alu_sum;
            state_in = S_NL2;
         end
         S_NL2: begin
            alu_op    = ALU_SUB;
            alu_a     = tmp_ff;
            alu_b     = CW'(col_ff);
            cursor_in = alu_sum;
            col_in    = '0;
            if (alu_sum == CELLS_C) begin
               ptr_in   = '0;
               kind_in  = K_POST;
               state_in = S_SCR_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BS1: begin
            alu_op    = ALU_SUB;
            ram_we    = 1'b1;
            ram_waddr = AW'(alu_sum);
            cursor_in = alu_sum;
            col_in    = col_dec;
            // landing in a last column skips back over a wrapped blank tail
            state_in  = (col_dec == COL_LAST) ? S_BS2 : S_DONE;
         end
         S_BS2: begin
            alu_op = ALU_SUB;
            if (at_home) begin
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_BS3;
            end
         end
         S_BS3: begin
            alu_op = ALU_SUB;
            if (rd_cell.chr == CH_NUL) begin
               cursor_in = alu_sum;
               col_in    = col_dec;
               state_in  = S_BS2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LF1: begin
            alu_op = ALU_SUB;
            if (at_home) begin
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               cursor_in = alu_sum;
               col_in    = col_dec;
               state_in  = S_LF2;
            end
         end
         S_LF2: begin
            state_in = (rd_cell.chr != CH_NUL) ? S_DONE : S_LF1;
         end
         S_RT1: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(cursor_ff);
            state_in  = S_RT2;
         end
         S_RT2: begin
            if (alu_sum != CELLS_C && rd_cell.chr != CH_NUL) begin
               cursor_in = alu_sum;
               col_in    = col_inc;
            end
            state_in = S_DONE;
         end
         S_UP1: begin
            alu_op = ALU_SUB;
            alu_b  = COLS_C;
            if (alu_borrow) begin
               state_in = S_DONE;
            end else begin
               tmp_in   = alu_sum;
               state_in = S_UP2;
            end
         end
         S_UP2: begin
            alu_op    = ALU_SUB;
            alu_a     = tmp_ff;
            alu_b     = CW'(col_ff);
            cursor_in = alu_sum;
            col_in    = '0;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{cursor_index: IDX_W'(cursor_ff),
                                cell_char:    cell_ff.chr,
                                cell_color:   cell_ff.color};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         kind_ff      <= K_INIT;
         cursor_ff    <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff      <= tmp_in;
      req_ff      <= req_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cursor never runs past the end position
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CELLS_C)
      else $error("cursor beyond end of screen");

   // column tracker agrees with the cursor at both ends of the screen
   a_col_track: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff == '0 || cursor_ff == CELLS_C) |-> col_ff == '0)
      else $error("column tracker out of step with cursor");

   // a finished transaction waits while the output register is still full
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> state_ff == S_DONE)
      else $error("response overwritten while stalled");

   // reset always starts the blanking sweep
   a_reset_sweep: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == S_CLR && kind_ff == K_INIT))
      else $error("no blanking sweep after reset");

endmodule

`default_nettype wire

/* hw/rtl/tcce_ram.sv */
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/tcce_alu.sv */
// ----------------------------------------------------------------------------
// tcce_alu
// Shared add / subtract unit; the top bit of the result is carry or borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_alu #(
   parameter int WIDTH = 11
) (
   input  wire tcce_pkg::alu_op_type op,
   input  wire logic [WIDTH-1:0]    opa,
   input  wire logic [WIDTH-1:0]    opb,
   output logic      [WIDTH:0]      result
);

   import tcce_pkg::*;

   always_comb begin
      unique case (op)
         ALU_ADD: result = {1'b0, opa} + {1'b0, opb};
         ALU_SUB: result = {1'b0, opa} - {1'b0, opb};
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console char engine. A short table of
// hand-picked requests is followed by random runs of text, cursor keys,
// reads, clears and runs to the bottom of the screen that force scrolls.
// Each reply is checked against the shadow screen or a pinned reply.
// ----------------------------------------------------------------------------

module tb_top;
   import tcce_pkg::*;

   localparam int SCREEN_COLS  = COLUMNS_DEF;
   localparam int SCREEN_ROWS  = ROWS_DEF;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int ITEMS        = 550;
   localparam int OPENING_N    = 28;

   // mode that the block leaves unused
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      req_type item;
      logic    pinned;   // reply typed in below rather than predicted
      rsp_type reply;
   } probe_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow of the console state
   cell_type         screen_copy [SCREEN_CELLS];
   logic [IDX_W-1:0] caret;
   logic [IDX_W-1:0] lock_edge;

   rsp_type       cursor_cell_replies [$];
   probe_row_type opening_rows [OPENING_N];

   int  faults;
   int  requests_sent;
   int  replies_checked;
   int  scrolls_seen;
   int  clears_seen;
   int  reads_seen;
   bit  sender_quiet;

   text_console_char_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // random field values
   // ------------------------------------------------------------------------
   function automatic logic [CHAR_W-1:0] any_byte();
      return CHAR_W'($urandom_range(255, 0));
   endfunction

   function automatic logic [IDX_W-1:0] any_index();
      return IDX_W'($urandom_range(2047, 0));
   endfunction

   // ------------------------------------------------------------------------
   // shadow console
   // ------------------------------------------------------------------------
   function automatic void blank_screen();
      int k;
      for (k = 0; k < SCREEN_CELLS; k++) begin
         screen_copy[k] = BLANK_CELL;
      end
      caret = '0;
   endfunction

   function automatic void shift_rows_up();
      int k;
      for (k = SCREEN_COLS; k < SCREEN_CELLS; k++) begin
         screen_copy[k - SCREEN_COLS] = screen_copy[k];
      end
      for (k = SCREEN_CELLS - SCREEN_COLS; k < SCREEN_CELLS; k++) begin
         screen_copy[k] = BLANK_CELL;
      end
      caret     = (caret >= SCREEN_COLS) ? IDX_W'(caret - SCREEN_COLS) : '0;
      lock_edge = (lock_edge >= SCREEN_COLS) ? IDX_W'(lock_edge - SCREEN_COLS) : '0;
      scrolls_seen++;
   endfunction

   function automatic void place_glyph(input logic [CHAR_W-1:0] ch,
                                       input logic [CHAR_W-1:0] col);
      if (caret < SCREEN_CELLS) begin
         screen_copy[caret].chr   = ch;
         screen_copy[caret].color = col;
         caret++;
      end else begin
         caret = IDX_W'(SCREEN_CELLS);
      end
   endfunction

   function automatic rsp_type emulate_console(input req_type item);
      rsp_type reply;
      bit      walking;
      reply = '0;
      case (item.mode)
         MODE_CHAR: begin
            if (item.char_code != CH_NUL) begin
               // a pending scroll is taken before any non-zero byte
               if (caret >= SCREEN_CELLS) shift_rows_up();
               case (item.char_code) inside
                  CH_TAB: begin
                     repeat (4) place_glyph(CH_SPACE, item.color);
                  end
                  CH_LF: begin
                     caret = IDX_W'(caret - (caret % SCREEN_COLS) + SCREEN_COLS);
                     if (caret >= SCREEN_CELLS) shift_rows_up();
                  end
                  CH_CR, CH_DOWN: begin
                  end
                  CH_BS: begin
                     if (caret > lock_edge) begin
                        caret--;
                        screen_copy[caret] = BLANK_CELL;
                        // landed on a line end: fall back over the empty tail
                        if (caret % SCREEN_COLS == SCREEN_COLS - 1) begin
                           while (caret > 0 && screen_copy[caret - 1].chr == CH_NUL)
                              caret--;
                        end
                     end
                  end
                  CH_LEFT: begin
                     walking = 1'b1;
                     while (walking) begin
                        if (caret == 0 || caret - 1 < lock_edge) begin
                           caret   = lock_edge;
                           walking = 1'b0;
                        end else begin
                           caret--;
                           if (screen_copy[caret].chr != CH_NUL) walking = 1'b0;
                        end
                     end
                  end
                  CH_RIGHT: begin
                     if (caret + 1 < SCREEN_CELLS && screen_copy[caret].chr != CH_NUL)
                        caret++;
                  end
                  CH_UP: begin
                     if (caret >= SCREEN_COLS && caret - SCREEN_COLS >= lock_edge)
                        caret = IDX_W'(caret - (caret % SCREEN_COLS) - SCREEN_COLS);
                  end
                  default: begin
                     place_glyph(item.char_code, item.color);
                  end
               endcase
            end
         end
         MODE_READ: begin
            reads_seen++;
            if (item.cell_index < SCREEN_CELLS) begin
               reply.cell_char  = screen_copy[item.cell_index].chr;
               reply.cell_color = screen_copy[item.cell_index].color;
            end
         end
         MODE_CLEAR: begin
            clears_seen++;
            blank_screen();
         end
         default: begin
         end
      endcase
      reply.cursor_index = caret;
      return reply;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type make_item(input logic [MODE_W-1:0] mode,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [CHAR_W-1:0] col,
                                         input logic [IDX_W-1:0]  idx);
      return {mode, ch, col, idx};
   endfunction

   function automatic probe_row_type probe(input logic [MODE_W-1:0] mode,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic [CHAR_W-1:0] col,
                                           input logic [IDX_W-1:0]  idx,
                                           input logic              pinned,
                                           input logic [IDX_W-1:0]  cur,
                                           input logic [CHAR_W-1:0] rd_chr,
                                           input logic [CHAR_W-1:0] rd_col);
      return {mode, ch, col, idx, pinned, cur, rd_chr, rd_col};
   endfunction

   // any byte that is printed rather than acted on
   function automatic logic [CHAR_W-1:0] glyph_byte();
      logic [CHAR_W-1:0] b;
      if ($urandom_range(9) < 7) begin
         b = CHAR_W'($urandom_range(8'h7E, 8'h20));
      end else begin
         b = CHAR_W'($urandom_range(255, 1));
         case (b) inside
            CH_BS, CH_TAB, CH_LF, CH_CR, CH_RIGHT, CH_LEFT, CH_UP, CH_DOWN:
               b = b | 8'h40;
            default: begin
            end
         endcase
      end
      return b;
   endfunction

   task automatic send_item(input req_type item, input logic pinned,
                            input rsp_type fixed);
      int gap;
      int roll;
      if (sender_quiet) begin
         gap = 0;
      end else begin
         roll = $urandom_range(99);
         if (roll < 65)      gap = 0;
         else if (roll < 95) gap = $urandom_range(3, 1);
         else                gap = $urandom_range(60, 15);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // transaction taken at this edge
      fixed_or_predicted: begin
         rsp_type predicted;
         predicted = emulate_console(item);
         cursor_cell_replies.push_back(pinned ? fixed : predicted);
      end
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] col);
      send_item(make_item(MODE_CHAR, ch, col, any_index()), 1'b0, '0);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(negedge clock); while (cursor_cell_replies.size() != 0);
   endtask

   function automatic void flag_fault(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
      faults++;
      $error("%s: expected %0h, actual %0h", field, want, got);
   endfunction

   // ------------------------------------------------------------------------
   // reply side: random stall and checking
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : rsp_back_pressure
      int roll;
      int hold_left;
      int quiet_left;
      if (quiet_left > 0) begin
         quiet_left = quiet_left - 1;
         hold_left  = 0;
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end else begin
         roll = $urandom_range(999);
         if (roll < 2) begin
            quiet_left = $urandom_range(400, 100);
            rsp_stall <= 1'b0;
         end else if (roll < 650) begin
            rsp_stall <= 1'b0;
         end else if (roll < 970) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(2, 0);
         end else begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(60, 20);
         end
      end
   end

   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (cursor_cell_replies.size() == 0) begin
            flag_fault("unexpected transaction, cursor_index", '0,
                       32'(rsp_data.cursor_index));
         end else begin
            want = cursor_cell_replies.pop_front();
            replies_checked++;
            if (rsp_data.cursor_index !== want.cursor_index)
               flag_fault("cursor_index", 32'(want.cursor_index),
                          32'(rsp_data.cursor_index));
            if (rsp_data.cell_char !== want.cell_char)
               flag_fault("cell_char", 32'(want.cell_char), 32'(rsp_data.cell_char));
            if (rsp_data.cell_color !== want.cell_color)
               flag_fault("cell_color", 32'(want.cell_color), 32'(rsp_data.cell_color));
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int               pick;
      int               n;
      int               next_drain;
      int               low_idx;
      logic [IDX_W-1:0] idx;

      blank_screen();
      lock_edge = '0;

      // after reset every cell is blank, cursor home
      opening_rows[0]  = probe(MODE_READ, CH_NUL, 8'h00, 11'd0, 1'b1, 11'd0, CH_NUL, BLANK_COLOR);
      opening_rows[1]  = probe(MODE_READ, CH_NUL, 8'h00, 11'd1999, 1'b1, 11'd0, CH_NUL,
                               BLANK_COLOR);
      opening_rows[2]  = probe(MODE_READ, 8'hFF, 8'hFF, 11'h7FF, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[3]  = probe(MODE_SPARE, 8'hFF, 8'hFF, 11'h7FF, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[4]  = probe(MODE_CHAR, CH_NUL, 8'hFF, 11'd0, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[5]  = probe(MODE_CHAR, CH_LEFT, 8'h00, 11'd0, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[6]  = probe(MODE_CHAR, CH_UP, 8'h00, 11'd0, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[7]  = probe(MODE_CHAR, CH_BS, 8'h00, 11'd0, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[8]  = probe(MODE_CHAR, 8'h41, 8'hFF, 11'd0, 1'b1, 11'd1, 8'h00, 8'h00);
      opening_rows[9]  = probe(MODE_READ, CH_NUL, 8'h00, 11'd0, 1'b1, 11'd1, 8'h41, 8'hFF);
      opening_rows[10] = probe(MODE_CHAR, 8'hFF, 8'h00, 11'd0, 1'b1, 11'd2, 8'h00, 8'h00);
      // right over an empty cell goes nowhere
      opening_rows[11] = probe(MODE_CHAR, CH_RIGHT, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[12] = probe(MODE_CHAR, CH_LEFT, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[13] = probe(MODE_CHAR, CH_RIGHT, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[14] = probe(MODE_CHAR, CH_TAB, 8'h5A, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[15] = probe(MODE_READ, CH_NUL, 8'h00, 11'd5, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[16] = probe(MODE_CHAR, CH_BS, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[17] = probe(MODE_READ, CH_NUL, 8'h00, 11'd5, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[18] = probe(MODE_CHAR, CH_LF, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[19] = probe(MODE_CHAR, CH_UP, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[20] = probe(MODE_CHAR, CH_CR, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[21] = probe(MODE_CHAR, CH_DOWN, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[22] = probe(MODE_CHAR, CH_LF, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[23] = probe(MODE_CHAR, CH_LF, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      // backspace to a line end falls back over the empty rows above
      opening_rows[24] = probe(MODE_CHAR, CH_BS, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[25] = probe(MODE_CHAR, CH_LEFT, 8'h00, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00);
      opening_rows[26] = probe(MODE_CLEAR, 8'hFF, 8'hFF, 11'h7FF, 1'b1, 11'd0, 8'h00, 8'h00);
      opening_rows[27] = probe(MODE_READ, CH_NUL, 8'h00, 11'd0, 1'b1, 11'd0, CH_NUL,
                               BLANK_COLOR);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_quiet = 1'b1;
      for (n = 0; n < OPENING_N; n++) begin
         send_item(opening_rows[n].item, opening_rows[n].pinned, opening_rows[n].reply);
      end
      drain_replies();

      sender_quiet = 1'b0;
      next_drain   = requests_sent + 150;
      while (requests_sent < ITEMS) begin
         if ($urandom_range(9) == 0) sender_quiet = !sender_quiet;
         if (requests_sent >= next_drain) begin
            drain_replies();
            next_drain = requests_sent + 150;
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            // a line of text, usually ended by a newline
            repeat ($urandom_range(40, 1)) begin
               if ($urandom_range(9) == 0) send_char(CH_TAB, any_byte());
               else                        send_char(glyph_byte(), any_byte());
            end
            if ($urandom_range(9) < 7) send_char(CH_LF, any_byte());
         end else if (pick < 65) begin
            repeat ($urandom_range(8, 1)) begin
               case ($urandom_range(6))
                  0:       send_char(CH_BS,    any_byte());
                  1:       send_char(CH_LEFT,  any_byte());
                  2:       send_char(CH_RIGHT, any_byte());
                  3:       send_char(CH_UP,    any_byte());
                  4:       send_char(CH_DOWN,  any_byte());
                  5:       send_char(CH_CR,    any_byte());
                  default: send_char(CH_NUL,   any_byte());
               endcase
            end
         end else if (pick < 80) begin
            repeat ($urandom_range(4, 1)) begin
               n = $urandom_range(9);
               low_idx = (caret > SCREEN_COLS) ? caret - SCREEN_COLS : 0;
               if (n < 5)      idx = IDX_W'($urandom_range(caret, low_idx));
               else if (n < 9) idx = IDX_W'($urandom_range(SCREEN_CELLS - 1, 0));
               else            idx = IDX_W'($urandom_range(2047, SCREEN_CELLS));
               send_item(make_item(MODE_READ, any_byte(), any_byte(), idx), 1'b0, '0);
            end
         end else if (pick < 86) begin
            // run down to the last row and fill it, then hit the pending scroll
            while (caret < SCREEN_CELLS - SCREEN_COLS) send_char(CH_LF, any_byte());
            while (caret < SCREEN_CELLS) begin
               if ($urandom_range(9) < 6) send_char(CH_TAB, any_byte());
               else                       send_char(glyph_byte(), any_byte());
            end
            case ($urandom_range(9))
               0: send_char(CH_NUL,   any_byte());
               1: send_char(CH_CR,    any_byte());
               2: send_char(CH_TAB,   any_byte());
               3: send_char(CH_LF,    any_byte());
               4: send_char(CH_BS,    any_byte());
               5: send_char(CH_LEFT,  any_byte());
               6: send_char(CH_RIGHT, any_byte());
               7: send_char(CH_UP,    any_byte());
               8: send_item(make_item(MODE_READ, 8'h00, 8'h00,
                                      IDX_W'($urandom_range(SCREEN_CELLS - 1, 0))),
                            1'b0, '0);
               default: send_char(glyph_byte(), any_byte());
            endcase
         end else if (pick < 88) begin
            send_item(make_item(MODE_CLEAR, any_byte(), any_byte(), any_index()), 1'b0, '0);
         end else if (pick < 90) begin
            send_item(make_item(MODE_SPARE, any_byte(), any_byte(), any_index()), 1'b0, '0);
         end else begin
            // noise: any mode, any field
            send_item(make_item(MODE_W'($urandom_range(3, 0)), any_byte(), any_byte(),
                                any_index()), 1'b0, '0);
         end
      end

      drain_replies();
      repeat (40) @(negedge clock);

      $display("summary: %0d requests sent, %0d replies checked, %0d read",
               requests_sent, replies_checked, reads_seen);
      $display("summary: %0d scrolls and %0d screen clears predicted",
               scrolls_seen, clears_seen);
      if (faults == 0 && cursor_cell_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #400_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ram.sv
hw/rtl/tcce_alu.sv
hw/rtl/text_console_char_engine.sv
bench/tb_top.sv
